/* rtl/core/cesd_pkg.sv */
// Shared types and character constants for the C escape sequence decoder.
package cesd_pkg;

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_BSLASH = 3'd1,
        M_ZERO   = 3'd2,
        M_OCTFIX = 3'd3,
        M_OCTVAR = 3'd4,
        M_HEX    = 3'd5
    } mode_t;

    typedef struct packed {
        logic [15:0] unit;
        logic        uvalid;
        logic        last;
    } res_t;

    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_0      = 16'h0030;
    localparam logic [15:0] CH_1      = 16'h0031;
    localparam logic [15:0] CH_7      = 16'h0037;
    localparam logic [15:0] CH_9      = 16'h0039;
    localparam logic [15:0] CH_LA     = 16'h0061;
    localparam logic [15:0] CH_LF     = 16'h0066;
    localparam logic [15:0] CH_UA     = 16'h0041;
    localparam logic [15:0] CH_UF     = 16'h0046;
    localparam logic [15:0] CH_U      = 16'h0075;
    localparam logic [15:0] CH_X      = 16'h0078;
    localparam logic [15:0] CH_B      = 16'h0062;
    localparam logic [15:0] CH_T      = 16'h0074;
    localparam logic [15:0] CH_N      = 16'h006E;
    localparam logic [15:0] CH_V      = 16'h0076;
    localparam logic [15:0] CH_R      = 16'h0072;

    localparam logic [15:0] CC_BEL = 16'd7;
    localparam logic [15:0] CC_BS  = 16'd8;
    localparam logic [15:0] CC_HT  = 16'd9;
    localparam logic [15:0] CC_LF  = 16'd10;
    localparam logic [15:0] CC_VT  = 16'd11;
    localparam logic [15:0] CC_FF  = 16'd12;
    localparam logic [15:0] CC_CR  = 16'd13;

    localparam logic [2:0] OCT_DIGITS = 3'd3;
    localparam logic [2:0] HEX_DIGITS = 3'd4;

endpackage

/* rtl/core/c_escape_sequence_decoder.sv */
// Top level of the C escape sequence decoder: input register, decode logic, result queue.
//
// Decodes C-style backslash escapes in a stream of 16-bit code units. Each input item
// (s_tdata = code unit, s_tlast = end of string) is captured in an input register, decoded
// combinationally against the escape state, and its zero, one or two result items are
// pushed into a three-entry result queue that feeds the master side. The block takes one
// item per cycle while the queue has room to take its results; an item that yields two
// results (an octal escape ended early by a plain character) fills the queue further, so
// the next item waits until a result drains through the output port, which sends a single
// result per cycle. Results pass through the input register and then the result queue.
// Every string ends with a result carrying m_tlast; if the last unit gives no character,
// an empty marker with m_tuser = 0 and m_tdata = 0 is sent.
module c_escape_sequence_decoder
    import cesd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] in_unit
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_unit
    output logic        m_tuser,   // [0] out_valid
    output logic        m_tlast    // out_last
);

    // input register
    logic        in_vld_reg;
    logic [15:0] in_unit_reg;
    logic        in_last_reg;
    logic        consume;

    // escape state
    mode_t       mode_reg, mode_next;
    logic [15:0] val_reg, val_next;
    logic [2:0]  dig_reg, dig_next;
    logic        err_reg, err_next;

    // result queue, head at entry 0
    res_t        q_reg [3];
    res_t        q_next [3];
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    // decode results
    res_t        res [2];
    logic [1:0]  n_res;

    assign consume  = in_vld_reg && (cnt_reg <= 2'd1);
    assign s_tready = !in_vld_reg || consume;
    assign pop      = (cnt_reg != 2'd0) && m_tready;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = q_reg[0].unit;
    assign m_tuser  = q_reg[0].uvalid;
    assign m_tlast  = q_reg[0].last;

    // decode of one code unit
    always_comb
    begin
        logic [15:0] u;
        logic        is_oct;
        logic        is_hex;
        logic [3:0]  hval;
        logic [15:0] c;
        logic [2:0]  dinc;

        u         = in_unit_reg;
        mode_next = mode_reg;
        val_next  = val_reg;
        dig_next  = dig_reg;
        err_next  = err_reg;
        n_res     = 2'd0;
        res[0]    = '0;
        res[1]    = '0;
        is_oct    = (u >= CH_0) && (u <= CH_7);
        is_hex    = 1'b1;
        hval      = u[3:0];
        c         = u;
        dinc      = dig_reg + 3'd1;

        if ((u >= CH_0) && (u <= CH_9))
            hval = u[3:0];
        else if (((u >= CH_LA) && (u <= CH_LF)) || ((u >= CH_UA) && (u <= CH_UF)))
            hval = u[3:0] + 4'd9;
        else
            is_hex = 1'b0;

        unique case (mode_reg)
            M_BSLASH:
            begin
                mode_next = M_NORMAL;
                val_next  = '0;
                dig_next  = '0;
                err_next  = 1'b0;
                if (u == CH_0)
                    mode_next = M_ZERO;
                else if ((u >= CH_1) && (u <= CH_7))
                begin
                    mode_next = M_OCTVAR;
                    val_next  = {13'd0, u[2:0]};
                    dig_next  = 3'd1;
                end
                else if ((u == CH_U) || (u == CH_X))
                    mode_next = M_HEX;
                else
                begin
                    if (u == CH_LA)      c = CC_BEL;
                    else if (u == CH_B)  c = CC_BS;
                    else if (u == CH_T)  c = CC_HT;
                    else if (u == CH_N)  c = CC_LF;
                    else if (u == CH_V)  c = CC_VT;
                    else if (u == CH_LF) c = CC_FF;
                    else if (u == CH_R)  c = CC_CR;
                    res[0] = '{unit: c, uvalid: 1'b1, last: 1'b0};
                    n_res  = 2'd1;
                end
            end
            M_ZERO:
            begin
                if (is_oct)
                begin
                    mode_next = M_OCTFIX;
                    val_next  = {13'd0, u[2:0]};
                    dig_next  = 3'd1;
                    err_next  = 1'b0;
                end
                else
                begin
                    res[0]    = '{unit: 16'd0, uvalid: 1'b1, last: 1'b0};
                    n_res     = 2'd1;
                    mode_next = M_NORMAL;
                    val_next  = '0;
                    dig_next  = '0;
                    err_next  = 1'b0;
                    if (u == CH_BSLASH)
                        mode_next = M_BSLASH;
                    else
                    begin
                        res[1] = '{unit: u, uvalid: 1'b1, last: 1'b0};
                        n_res  = 2'd2;
                    end
                end
            end
            M_OCTFIX:
            begin
                if (is_oct)
                    val_next = {val_reg[12:0], u[2:0]};
                else
                    err_next = 1'b1;
                dig_next = dinc;
                if (dinc >= OCT_DIGITS)
                begin
                    res[0]    = '{unit: (err_next ? 16'd0 : val_next), uvalid: 1'b1,
                                  last: 1'b0};
                    n_res     = 2'd1;
                    mode_next = M_NORMAL;
                    val_next  = '0;
                    dig_next  = '0;
                    err_next  = 1'b0;
                end
            end
            M_OCTVAR:
            begin
                if (is_oct)
                begin
                    val_next = {val_reg[12:0], u[2:0]};
                    dig_next = dinc;
                    if (dinc >= OCT_DIGITS)
                    begin
                        res[0]    = '{unit: val_next, uvalid: 1'b1, last: 1'b0};
                        n_res     = 2'd1;
                        mode_next = M_NORMAL;
                        val_next  = '0;
                        dig_next  = '0;
                        err_next  = 1'b0;
                    end
                end
                else
                begin
                    // octal run ended early; the unit is then taken as plain or opens a new escape
                    res[0]    = '{unit: val_reg, uvalid: 1'b1, last: 1'b0};
                    n_res     = 2'd1;
                    mode_next = M_NORMAL;
                    val_next  = '0;
                    dig_next  = '0;
                    err_next  = 1'b0;
                    if (u == CH_BSLASH)
                        mode_next = M_BSLASH;
                    else
                    begin
                        res[1] = '{unit: u, uvalid: 1'b1, last: 1'b0};
                        n_res  = 2'd2;
                    end
                end
            end
            M_HEX:
            begin
                if (is_hex)
                    val_next = {val_reg[11:0], hval};
                else
                    err_next = 1'b1;
                dig_next = dinc;
                if (dinc >= HEX_DIGITS)
                begin
                    res[0]    = '{unit: (err_next ? 16'd0 : val_next), uvalid: 1'b1,
                                  last: 1'b0};
                    n_res     = 2'd1;
                    mode_next = M_NORMAL;
                    val_next  = '0;
                    dig_next  = '0;
                    err_next  = 1'b0;
                end
            end
            default:
            begin
                mode_next = M_NORMAL;
                val_next  = '0;
                dig_next  = '0;
                err_next  = 1'b0;
                if (u == CH_BSLASH)
                    mode_next = M_BSLASH;
                else
                begin
                    res[0] = '{unit: u, uvalid: 1'b1, last: 1'b0};
                    n_res  = 2'd1;
                end
            end
        endcase

        if (in_last_reg)
        begin
            // flush an open numeric escape at end of string
            if (mode_next == M_ZERO || mode_next == M_OCTFIX || mode_next == M_HEX
                || mode_next == M_OCTVAR)
            begin
                if (mode_next == M_ZERO)
                    c = 16'd0;
                else if (mode_next == M_OCTVAR)
                    c = val_next;
                else
                    c = err_next ? 16'd0 : val_next;
                res[n_res[0]] = '{unit: c, uvalid: 1'b1, last: 1'b0};
                n_res         = n_res + 2'd1;
            end
            mode_next = M_NORMAL;
            val_next  = '0;
            dig_next  = '0;
            err_next  = 1'b0;
            if (n_res == 2'd0)
            begin
                res[0] = '{unit: 16'd0, uvalid: 1'b0, last: 1'b0};
                n_res  = 2'd1;
            end
            res[n_res[0] ^ 1'b1].last = 1'b1;
        end
    end

    // result queue update
    always_comb
    begin
        logic [1:0] cn;

        q_next = q_reg;
        cn     = cnt_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            cn        = cn - 2'd1;
        end
        if (consume)
        begin
            if (n_res != 2'd0)
            begin
                q_next[cn] = res[0];
                cn         = cn + 2'd1;
            end
            if (n_res == 2'd2)
            begin
                q_next[cn] = res[1];
                cn         = cn + 2'd1;
            end
        end
        cnt_next = cn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            mode_reg   <= M_NORMAL;
            val_reg    <= '0;
            dig_reg    <= '0;
            err_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (consume)
            begin
                mode_reg <= mode_next;
                val_reg  <= val_next;
                dig_reg  <= dig_next;
                err_reg  <= err_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_unit_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        q_reg <= q_next;
    end

    // every string end produces at least one result
    a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        consume && in_last_reg |-> n_res != 2'd0)
        else $error("end of string produced no result");

    // the escape state is cleared once a string ends
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        consume && in_last_reg |=> mode_reg == M_NORMAL && val_reg == 16'd0
                                   && dig_reg == 3'd0 && err_reg == 1'b0)
        else $error("escape state not cleared after end of string");

    // digit count stays within the longest fixed escape
    a_digits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        dig_reg < HEX_DIGITS)
        else $error("digit count out of range");

    // outside an escape, the accumulator is idle
    a_normal_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_NORMAL |-> val_reg == 16'd0 && dig_reg == 3'd0)
        else $error("accumulator busy in normal mode");

endmodule
